### rtl/rgbcsc_pkg.sv
package rgbcsc_pkg;

    localparam int PIX_W   = 8;
    localparam int MODE_W  = 2;
    localparam int FRAC_W  = 16;
    localparam int COEF_W  = 17;
    localparam int PROD_W  = COEF_W + PIX_W + 1;
    localparam int OFFS_W  = 25;
    localparam int ACC_W   = PROD_W + 1;
    localparam int WHOLE_W = ACC_W - 1 - FRAC_W;
    localparam int NCHAN   = 3;

    localparam logic [PIX_W-1:0] CHAN_MAX = 8'd255;

    localparam logic [MODE_W-1:0] CONV_MODE_CMY = 2'd0;
    localparam logic [MODE_W-1:0] CONV_MODE_XYZ = 2'd1;
    localparam logic [MODE_W-1:0] CONV_MODE_YUV = 2'd2;

    typedef logic [MODE_W-1:0]        t_mode;
    typedef logic signed [COEF_W-1:0] t_coef;
    typedef logic signed [OFFS_W-1:0] t_offs;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [PIX_W-1:0] chan_first;
        logic [PIX_W-1:0] chan_second;
        logic [PIX_W-1:0] chan_third;
    } t_chan;

    // Coefficients in Q16, rounded to nearest
    localparam t_coef XYZ_COEF [NCHAN][NCHAN] = '{
        '{17'sd27031, 17'sd23434, 17'sd11824},
        '{17'sd13938, 17'sd46869, 17'sd4730},
        '{17'sd1267,  17'sd7811,  17'sd62274}
    };

    localparam t_coef YUV_COEF [NCHAN][NCHAN] = '{
        '{ 17'sd19595,  17'sd38470,  17'sd7471},
        '{-17'sd11076, -17'sd21758,  17'sd32768},
        '{ 17'sd32768, -17'sd27460, -17'sd5328}
    };

    localparam t_offs XYZ_OFFS [NCHAN] = '{25'sd0, 25'sd0, 25'sd0};
    localparam t_offs YUV_OFFS [NCHAN] = '{25'sd0, 25'sd8388608, 25'sd8388608};

endpackage

### rtl/rgbcsc_row.sv
module rgbcsc_row (
    input  rgbcsc_pkg::t_pixel                  i_pix,
    input  rgbcsc_pkg::t_coef                   i_coef_r,
    input  rgbcsc_pkg::t_coef                   i_coef_g,
    input  rgbcsc_pkg::t_coef                   i_coef_b,
    input  rgbcsc_pkg::t_offs                   i_offs,
    output logic [rgbcsc_pkg::PIX_W-1:0]        o_chan
);
    import rgbcsc_pkg::*;

    logic signed [PROD_W-1:0]  prod_r;
    logic signed [PROD_W-1:0]  prod_g;
    logic signed [PROD_W-1:0]  prod_b;
    logic signed [ACC_W-1:0]   acc;
    logic [WHOLE_W-1:0]        whole;

    assign prod_r = i_coef_r * $signed({1'b0, i_pix.red});
    assign prod_g = i_coef_g * $signed({1'b0, i_pix.green});
    assign prod_b = i_coef_b * $signed({1'b0, i_pix.blue});

    assign acc = ACC_W'(i_offs) + ACC_W'(prod_r) + ACC_W'(prod_g) + ACC_W'(prod_b);
    assign whole = acc[ACC_W-2:FRAC_W];

    // floor, then clamp to 0..255
    always_comb begin
        if (acc[ACC_W-1]) begin
            o_chan = '0;
        end else if (whole > WHOLE_W'(CHAN_MAX)) begin
            o_chan = CHAN_MAX;
        end else begin
            o_chan = whole[PIX_W-1:0];
        end
    end

endmodule

### rtl/rgbcsc_conv.sv
module rgbcsc_conv (
    input  rgbcsc_pkg::t_mode   i_mode,
    input  rgbcsc_pkg::t_pixel  i_pix,
    output rgbcsc_pkg::t_chan   o_chan
);
    import rgbcsc_pkg::*;

    logic                  is_yuv;
    logic [PIX_W-1:0]      mat_chan [NCHAN];

    assign is_yuv = (i_mode == CONV_MODE_YUV);

    for (genvar row = 0; row < NCHAN; row++) begin : g_row
        rgbcsc_row u_row (
            .i_pix    (i_pix),
            .i_coef_r (is_yuv ? YUV_COEF[row][0] : XYZ_COEF[row][0]),
            .i_coef_g (is_yuv ? YUV_COEF[row][1] : XYZ_COEF[row][1]),
            .i_coef_b (is_yuv ? YUV_COEF[row][2] : XYZ_COEF[row][2]),
            .i_offs   (is_yuv ? YUV_OFFS[row]    : XYZ_OFFS[row]),
            .o_chan   (mat_chan[row])
        );
    end

    always_comb begin
        case (i_mode)
            CONV_MODE_CMY: begin
                o_chan.chan_first  = CHAN_MAX - i_pix.red;
                o_chan.chan_second = CHAN_MAX - i_pix.green;
                o_chan.chan_third  = CHAN_MAX - i_pix.blue;
            end
            CONV_MODE_XYZ, CONV_MODE_YUV: begin
                o_chan.chan_first  = mat_chan[0];
                o_chan.chan_second = mat_chan[1];
                o_chan.chan_third  = mat_chan[2];
            end
            default: begin
                o_chan = '0;
            end
        endcase
    end

endmodule

### rtl/rgb_color_space_converter_top.sv
// RGB pixel converter: one 8-bit RGB pixel in, three 8-bit channels out, in the
// space picked by the mode register (0 CMY, 1 XYZ, 2 YUV with U/V offset 128,
// 3 gives all zeros). Matrix modes use Q16 coefficients; each sum is floored
// and clamped to 0..255. Two register stages (pixel register, result
// register) take one pixel per clock while the output is not stalled;
// the per-channel three-term constant multiply-add sits between them. Write
// the mode only while no pixel is in flight; the config port is always ready.
module rgb_color_space_converter_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  rgbcsc_pkg::t_pixel  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output rgbcsc_pkg::t_chan   o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  rgbcsc_pkg::t_mode   i_cfg_data
);
    import rgbcsc_pkg::*;

    t_mode   r_mode;
    logic    r_pix_valid;
    t_pixel  r_pix;
    logic    r_out_valid;
    t_chan   r_out;
    t_chan   n_out;
    logic    out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = !r_pix_valid || out_free;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= CONV_MODE_CMY;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_pix_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_pix <= i_in_data;
        end
    end

    rgbcsc_conv u_conv (
        .i_mode (r_mode),
        .i_pix  (r_pix),
        .o_chan (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_pix_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_pix_valid) begin
            r_out <= n_out;
        end
    end

endmodule

### rtl/rgbcsc_checker.sv
module rgbcsc_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  rgbcsc_pkg::t_chan   o_out_data
);

    logic in_xfer;
    assign in_xfer = i_in_valid && o_in_ready;

    // pipeline only backs up when the result register is stalled
    a_full_means_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a stalled result");

    // input reaches the output via pixel and result registers if sink ready
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer ##1 i_out_ready |=> o_out_valid)
        else $error("result missing after input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("result dropped or changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind rgb_color_space_converter_top rgbcsc_checker u_rgbcsc_checker (.*);
